// ===== hdl/b64le_pkg.sv =====
// Shared types, constants and the symbol table of the base64 line encoder.
// No dependencies; every other file of the block uses this package.
`default_nettype none

package b64le_pkg;

  // Job queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // Configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic REG_CHUNK_BYTES = 1'b0;   // register index, from paddr[2]
  localparam logic [7:0] CHUNK_RESET = 8'd54;

  // Special characters
  localparam logic [7:0] CHAR_CR  = 8'h0D;
  localparam logic [7:0] CHAR_LF  = 8'h0A;
  localparam logic [7:0] CHAR_PAD = 8'h3D;   // '='

  // Character slots within one job: four group slots, then CR and LF
  localparam logic [2:0] SLOT_GROUP_END = 3'd3;
  localparam logic [2:0] SLOT_LF        = 3'd5;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       out_last;
  } out_item_t;

  // One encode job: a group of three bytes (zero-filled), its pad count,
  // whether CR LF follows, and whether it ends the stream.
  typedef struct packed {
    logic [23:0] triple;
    logic [1:0]  pads;
    logic        crlf;
    logic        last;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Standard alphabet: A-Z a-z 0-9 + /
  function automatic logic [7:0] b64_char(input logic [5:0] v);
    logic [7:0] v8;
    logic [7:0] c;
    v8 = {2'b00, v};
    if (v8 < 8'd26) begin
      c = 8'h41 + v8;
    end else if (v8 < 8'd52) begin
      c = 8'h61 + (v8 - 8'd26);
    end else if (v8 < 8'd62) begin
      c = 8'h30 + (v8 - 8'd52);
    end else if (v8 == 8'd62) begin
      c = 8'h2B;
    end else begin
      c = 8'h2F;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/b64le_front.sv =====
// Front end: accepts bytes, collects groups of three, tracks line length
// and issues encode jobs. Depends on b64le_pkg.
`default_nettype none

module b64le_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire b64le_pkg::in_item_t in_data,
  input  wire logic               push,
  input  wire b64le_pkg::q_stat_t q_stat,
  input  wire logic [7:0]         chunk_bytes,
  output logic                    job_push,
  output b64le_pkg::job_t         job
);

  logic [15:0] held_r, held_nxt;
  logic [1:0]  fill_r, fill_nxt;
  logic [7:0]  line_r, line_nxt;
  logic        accept;
  logic        close;
  logic        wrap_on;
  logic [7:0]  line_inc;

  assign accept   = push && !q_stat.full;
  assign wrap_on  = (chunk_bytes != 8'd0);
  assign line_inc = wrap_on ? (line_r + 8'd1) : 8'd0;
  assign close    = in_data.last_byte || (wrap_on && (line_inc >= chunk_bytes));

  always_comb begin
    held_nxt   = held_r;
    fill_nxt   = fill_r;
    line_nxt   = line_r;
    job_push   = 1'b0;
    job.triple = 24'd0;
    job.pads   = 2'd0;
    job.crlf   = close && wrap_on;
    job.last   = in_data.last_byte;
    if (accept) begin
      line_nxt = line_inc;
      if (fill_r == 2'd2) begin
        // group complete: always emit
        job.triple = {held_r, in_data.data_byte};
        job.pads   = 2'd0;
        job_push   = 1'b1;
        held_nxt   = 16'd0;
        fill_nxt   = 2'd0;
      end else if (fill_r == 2'd1) begin
        job.triple = {held_r[15:8], in_data.data_byte, 8'd0};
        job.pads   = 2'd1;
        job_push   = close;
        held_nxt   = {held_r[15:8], in_data.data_byte};
        fill_nxt   = 2'd2;
      end else begin
        job.triple = {in_data.data_byte, 16'd0};
        job.pads   = 2'd2;
        job_push   = close;
        held_nxt   = {in_data.data_byte, 8'd0};
        fill_nxt   = 2'd1;
      end
      if (close) begin
        held_nxt = 16'd0;
        fill_nxt = 2'd0;
        line_nxt = 8'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= 16'd0;
      fill_r <= 2'd0;
      line_r <= 8'd0;
    end else begin
      held_r <= held_nxt;
      fill_r <= fill_nxt;
      line_r <= line_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/b64le_queue.sv =====
// Short job queue that decouples the front end from the character back end.
// Depends on b64le_pkg for the job and status types.
`default_nettype none

module b64le_queue #(
  parameter int DEPTH = b64le_pkg::QUEUE_DEPTH
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              wr_en,
  input  wire b64le_pkg::job_t   wr_job,
  input  wire logic              rd_en,
  output b64le_pkg::job_t        rd_job,
  output b64le_pkg::q_stat_t     q_stat
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  b64le_pkg::job_t slot_r [DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [CW-1:0] cnt_r;
  logic          do_wr, do_rd;

  assign q_stat.full  = (cnt_r == CW'(DEPTH));
  assign q_stat.empty = (cnt_r == CW'(0));
  assign do_wr  = wr_en && !q_stat.full;
  assign do_rd  = rd_en && !q_stat.empty;
  assign rd_job = slot_r[rp_r];

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? PW'(0) : p + PW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slot_r[wp_r] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_wr) begin
        wp_r <= ptr_inc(wp_r);
      end
      if (do_rd) begin
        rp_r <= ptr_inc(rp_r);
      end
      if (do_wr && !do_rd) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (do_rd && !do_wr) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/b64le_back.sv =====
// Back end: walks the head job one character per cycle into the output
// register when free or popped; uses b64le_pkg types, constants, alphabet.
`default_nettype none

module b64le_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire b64le_pkg::job_t    job,
  input  wire b64le_pkg::q_stat_t q_stat,
  output logic                    job_pop,
  output b64le_pkg::out_item_t    out_data,
  output logic                    empty,
  input  wire logic               pop
);

  logic [2:0]           slot_r, slot_nxt;
  logic                 valid_r, valid_nxt;
  b64le_pkg::out_item_t item_r, item_nxt;
  logic                 advance;
  logic                 is_end;
  logic [5:0]           sym;
  logic [2:0]           pad_sum;
  logic [7:0]           ch;

  assign advance = !q_stat.empty && (!valid_r || pop);
  assign is_end  = job.crlf ? (slot_r == b64le_pkg::SLOT_LF)
                            : (slot_r == b64le_pkg::SLOT_GROUP_END);
  assign job_pop = advance && is_end;
  assign pad_sum = {1'b0, slot_r[1:0]} + {1'b0, job.pads};

  always_comb begin
    case (slot_r[1:0])
      2'd0:    sym = job.triple[23:18];
      2'd1:    sym = job.triple[17:12];
      2'd2:    sym = job.triple[11:6];
      default: sym = job.triple[5:0];
    endcase
    if (slot_r[2]) begin
      ch = slot_r[0] ? b64le_pkg::CHAR_LF : b64le_pkg::CHAR_CR;
    end else if (pad_sum >= 3'd4) begin
      ch = b64le_pkg::CHAR_PAD;
    end else begin
      ch = b64le_pkg::b64_char(sym);
    end
  end

  always_comb begin
    slot_nxt  = slot_r;
    valid_nxt = valid_r;
    item_nxt  = item_r;
    if (advance) begin
      item_nxt.out_char = ch;
      item_nxt.out_last = job.last && is_end;
      valid_nxt         = 1'b1;
      slot_nxt          = is_end ? 3'd0 : slot_r + 3'd1;
    end else if (pop) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r  <= 3'd0;
      valid_r <= 1'b0;
    end else begin
      slot_r  <= slot_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

  assign out_data = item_r;
  assign empty    = !valid_r;

endmodule

`default_nettype wire

// ===== hdl/base64_line_encoder.sv =====
// Base64 line encoder. Throughput: one byte per cycle in while the job queue
// has room, one character per cycle out while the output register is empty
// or popped; the back end's one-character-per-cycle serializer sets the rate,
// four characters per three bytes plus CR LF per line. Reset (rst_n low,
// synchronous) clears group, line and queue state and sets chunk_bytes to 54.
`default_nettype none

module base64_line_encoder #(
  parameter int QUEUE_DEPTH = b64le_pkg::QUEUE_DEPTH
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // input transaction channel
  input  wire b64le_pkg::in_item_t                 in_data,
  input  wire logic                                push,
  output logic                                     full,
  // result transaction channel
  output b64le_pkg::out_item_t                     out_data,
  output logic                                     empty,
  input  wire logic                                pop,
  // configuration port
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [b64le_pkg::CFG_ADDR_W-1:0]    paddr,
  input  wire logic [b64le_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [b64le_pkg::CFG_DATA_W-1:0]         prdata,
  output logic                                     pready
);

  logic [7:0]         chunk_r;
  logic               cfg_wr;
  logic               job_push;
  logic               job_pop;
  b64le_pkg::job_t    job_in;
  b64le_pkg::job_t    job_head;
  b64le_pkg::q_stat_t q_stat;

  // Configuration: one register; paddr[2] picks the word, low bits are the
  // byte offset and are ignored.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready
                  && (paddr[2] == b64le_pkg::REG_CHUNK_BYTES);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chunk_r <= b64le_pkg::CHUNK_RESET;
    end else if (cfg_wr) begin
      chunk_r <= pwdata[7:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == b64le_pkg::REG_CHUNK_BYTES) begin
      prdata[7:0] = chunk_r;
    end
  end

  // Front end: accept bytes whenever the job queue has room, so a full queue
  // is what holds the input channel off.
  assign full = q_stat.full;

  b64le_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_data     (in_data),
    .push        (push),
    .q_stat      (q_stat),
    .chunk_bytes (chunk_r),
    .job_push    (job_push),
    .job         (job_in)
  );

  // Queue of encode jobs; each job yields four characters, or six with CR LF.
  b64le_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (job_push),
    .wr_job (job_in),
    .rd_en  (job_pop),
    .rd_job (job_head),
    .q_stat (q_stat)
  );

  // Back end: drain the head job one character at a time into the output
  // register; advance while the register is empty or being popped.
  b64le_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .job      (job_head),
    .q_stat   (q_stat),
    .job_pop  (job_pop),
    .out_data (out_data),
    .empty    (empty),
    .pop      (pop)
  );

`ifndef SYNTHESIS
  // A waiting job must reach the output register on the next edge.
  assert property (@(posedge clk) disable iff (!rst_n)
    (!q_stat.empty && empty) |=> !empty)
    else $error("waiting job did not reach the output register");

  // CR is always followed at once by LF of the same job.
  assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && pop && out_data.out_char == b64le_pkg::CHAR_CR)
      |=> (!empty && out_data.out_char == b64le_pkg::CHAR_LF))
    else $error("CR not followed by LF");

  // The last flag only rides on LF or on a group character.
  assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_data.out_last) |-> (out_data.out_char != b64le_pkg::CHAR_CR))
    else $error("last flag on CR");
`endif

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for base64_line_encoder: drives byte streams and
// chunk sizes, predicts every output character and compares in order.
// Depends on b64le_pkg and the base64_line_encoder RTL only.

module testbench;

  localparam int  CYCLE_LIMIT  = 400000;
  localparam int  DRAIN_CYCLES = 20;
  localparam logic [b64le_pkg::CFG_ADDR_W-1:0] CHUNK_ADDR =
    {b64le_pkg::REG_CHUNK_BYTES, 2'b00};
  // Standard alphabet, symbol 0 in the top byte
  localparam logic [511:0] SYMBOLS =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  b64le_pkg::in_item_t  in_data = '0;
  logic                 push = 1'b0;
  logic                 full;
  b64le_pkg::out_item_t out_data;
  logic                 empty;
  logic                 pop = 1'b0;

  logic                                   psel = 1'b0;
  logic                                   penable = 1'b0;
  logic                                   pwrite = 1'b0;
  logic [b64le_pkg::CFG_ADDR_W-1:0]       paddr = '0;
  logic [b64le_pkg::CFG_DATA_W-1:0]       pwdata = '0;
  logic [b64le_pkg::CFG_DATA_W-1:0]       prdata;
  logic                                   pready;

  base64_line_encoder uut (
    .clk(clk), .rst_n(rst_n),
    .in_data(in_data), .push(push), .full(full),
    .out_data(out_data), .empty(empty), .pop(pop),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Bytes waiting to be driven, and characters the encoder still owes us
  b64le_pkg::in_item_t  tx_bytes[$];
  b64le_pkg::out_item_t expected_chars[$];
  int        bytes_queued = 0;
  int        bytes_taken = 0;
  int        errors = 0;
  int        cycles = 0;
  bit        gaps_on = 1'b0;

  // Predictor state: open group, bytes in the current line, chunk register
  logic [15:0] pair_buf = '0;
  logic [1:0]  pair_fill = '0;
  logic [7:0]  line_bytes = '0;
  logic [7:0]  chunk_size = b64le_pkg::CHUNK_RESET;

  function automatic logic [7:0] symbol(logic [5:0] v);
    return SYMBOLS[8*(63 - v) +: 8];
  endfunction

  // Encode one group of three bytes into four characters, the last 'pads' as '='
  function automatic void emit_quad(logic [23:0] triple, int pads);
    b64le_pkg::out_item_t c;
    for (int k = 0; k < 4; k++) begin
      c.out_last = 1'b0;
      if (k >= 4 - pads) begin
        c.out_char = b64le_pkg::CHAR_PAD;
      end else begin
        c.out_char = symbol(triple[23 - 6*k -: 6]);
      end
      expected_chars.push_back(c);
    end
  endfunction

  function automatic void emit_char(logic [7:0] ch);
    b64le_pkg::out_item_t c;
    c.out_char = ch;
    c.out_last = 1'b0;
    expected_chars.push_back(c);
  endfunction

  // Work out the characters that one accepted byte releases
  function automatic void encode_byte(b64le_pkg::in_item_t it);
    int   first;
    logic close;
    first = expected_chars.size();
    // with line breaks off the line counter stays at zero
    if (chunk_size != 0) begin
      line_bytes = line_bytes + 8'd1;
    end else begin
      line_bytes = '0;
    end
    close = it.last_byte || (chunk_size != 0 && line_bytes >= chunk_size);
    case (pair_fill)
      2'd2: begin
        emit_quad({pair_buf, it.data_byte}, 0);
        pair_buf  = '0;
        pair_fill = 2'd0;
      end
      2'd1: begin
        pair_buf[7:0] = it.data_byte;
        pair_fill     = 2'd2;
      end
      default: begin
        pair_buf  = {it.data_byte, 8'h00};
        pair_fill = 2'd1;
      end
    endcase
    if (close) begin
      // pad a partial group on its own: one byte -> "==", two bytes -> "="
      if (pair_fill != 0) begin
        emit_quad({pair_buf, 8'h00}, (pair_fill == 2'd1) ? 2 : 1);
      end
      if (chunk_size != 0) begin
        emit_char(b64le_pkg::CHAR_CR);
        emit_char(b64le_pkg::CHAR_LF);
      end
      pair_buf   = '0;
      pair_fill  = 2'd0;
      line_bytes = '0;
      if (it.last_byte && expected_chars.size() > first) begin
        expected_chars[expected_chars.size() - 1].out_last = 1'b1;
      end
    end
  endfunction

  // Driver: hold the byte until accepted, then advance or idle for a burst
  int send_gap = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      push     <= 1'b0;
      send_gap <= 0;
    end else if (!push || !full) begin
      if (send_gap != 0) begin
        send_gap <= send_gap - 1;
        push     <= 1'b0;
      end else if (tx_bytes.size() != 0) begin
        in_data <= tx_bytes.pop_front();
        push    <= 1'b1;
        if (gaps_on && $urandom_range(0, 7) == 0) begin
          send_gap <= $urandom_range(1, 16);
        end
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Receiver: pop by default, stall in random bursts
  int pop_stall = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      pop       <= 1'b0;
      pop_stall <= 0;
    end else if (pop_stall != 0) begin
      pop_stall <= pop_stall - 1;
      pop       <= 1'b0;
    end else begin
      pop <= 1'b1;
      if (gaps_on && $urandom_range(0, 7) == 0) begin
        pop_stall <= $urandom_range(1, 16);
      end
    end
  end

  // Monitor: check popped characters, track register writes, predict on push
  always @(posedge clk) begin : monitor
    b64le_pkg::out_item_t want;
    if (rst_n) begin
      if (pop && !empty) begin
        if (expected_chars.size() == 0) begin
          $error("unexpected character: out_char %h out_last %b",
                 out_data.out_char, out_data.out_last);
          errors++;
        end else begin
          want = expected_chars.pop_front();
          if (out_data.out_char !== want.out_char) begin
            $error("out_char: expected %h, actual %h", want.out_char, out_data.out_char);
            errors++;
          end
          if (out_data.out_last !== want.out_last) begin
            $error("out_last: expected %b, actual %b", want.out_last, out_data.out_last);
            errors++;
          end
        end
      end
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr == CHUNK_ADDR) begin
            chunk_size = pwdata[7:0];
          end
        end else if (prdata !== {24'h0, chunk_size}) begin
          $error("chunk_bytes: expected %h, actual %h", {24'h0, chunk_size}, prdata);
          errors++;
        end
      end
      if (push && !full) begin
        encode_byte(in_data);
        bytes_taken++;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("base64_line_encoder: mismatch");
      $finish;
    end
  end

  task automatic put_byte(logic [7:0] d, bit l);
    tx_bytes.push_back({d, l});
    bytes_queued++;
  endtask

  task automatic put_stream(int len, bit terminate);
    for (int i = 0; i < len; i++) begin
      put_byte(8'($urandom_range(0, 255)), terminate && (i == len - 1));
    end
  endtask

  // Mostly complete streams; some are cut short and carry into the next phase
  task automatic random_streams(int count, int max_len);
    int left;
    int len;
    left = count;
    while (left > 0) begin
      len = $urandom_range(1, max_len);
      if (len > left) begin
        len = left;
      end
      put_stream(len, $urandom_range(0, 9) != 0);
      left -= len;
    end
  endtask

  // Hold until every byte is taken and every character has come out,
  // then let a partial group settle inside the block
  task automatic wait_drained();
    while (bytes_taken != bytes_queued || expected_chars.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_access(bit wr, logic [7:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= CHUNK_ADDR;
    pwdata  <= {24'h0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_chunk(logic [7:0] value);
    wait_drained();
    cfg_access(1'b1, value);
    cfg_access(1'b0, 8'h00);
  endtask

  int sizes[8] = '{54, 0, 1, 2, 3, 6, 0, 128};
  int max_len;

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    // read back the reset value of the chunk register
    cfg_access(1'b0, 8'h00);

    // Directed: one-, two- and three-byte streams at the default line length
    gaps_on = 1'b1;
    put_byte(8'h00, 1'b1);
    put_byte(8'hFF, 1'b0);
    put_byte(8'hFF, 1'b1);
    put_byte(8'hFB, 1'b0);           // gives "+/+/"
    put_byte(8'hFF, 1'b0);
    put_byte(8'hBF, 1'b1);

    // one byte per line: every byte closes a padded line
    set_chunk(8'd1);
    put_byte(8'hA5, 1'b0);
    put_byte(8'h5A, 1'b0);
    put_byte(8'hC3, 1'b1);

    // line breaks off: plain base64, pad only at stream end
    set_chunk(8'd0);
    put_byte(8'hFF, 1'b0);
    put_byte(8'h00, 1'b0);
    put_byte(8'h80, 1'b0);
    put_byte(8'h7F, 1'b1);

    // lower the chunk size in the middle of a line
    set_chunk(8'd255);
    put_stream(5, 1'b0);
    set_chunk(8'd3);
    put_byte(8'h11, 1'b0);
    put_byte(8'h22, 1'b0);
    put_byte(8'h33, 1'b1);

    // switch line breaks off in the middle of a line
    set_chunk(8'd4);
    put_stream(2, 1'b0);
    set_chunk(8'd0);
    put_stream(3, 1'b1);

    // Random: a stream of more than one line at the largest chunk size, then a spread of sizes
    set_chunk(8'd255);
    gaps_on = $urandom_range(0, 3) != 0;
    put_stream(260, 1'b1);
    random_streams(10, 8);
    foreach (sizes[i]) begin
      set_chunk(8'(sizes[i]));
      gaps_on = $urandom_range(0, 3) != 0;
      max_len = (sizes[i] == 0 || sizes[i] > 6) ? 24 : 3 * sizes[i] + 4;
      random_streams(14, max_len);
    end

    // closing stretch with no idling on either side
    set_chunk(8'($urandom_range(1, 255)));
    gaps_on = 1'b0;
    random_streams(14, 24);

    wait_drained();
    if (errors == 0) begin
      $display("base64_line_encoder: match");
    end else begin
      $display("base64_line_encoder: mismatch");
    end
    $finish;
  end

endmodule
